>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Implication and next-cycle checks, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define BSF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BSF_ASSERT_IMPL(label, ante, cons, msg)
`define BSF_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/bsf_pkg.sv
// ----------------------------------------------------------------------------
// Bit-stuffed byte framer package
// Shared constants, types and the byte classification function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsf_pkg;

  localparam logic [7:0] FLAG_PATTERN = 8'h7E;
  localparam int         RUN_LIMIT    = 5;
  localparam int         QUEUE_DEPTH  = 2;

  // One classified byte: payload plus where its stuffed 0 goes.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_stuff;
    logic [2:0] stuff_pos;
  } bsf_item_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
  } bsf_q_stat_t;

  typedef enum logic [1:0] {
    PH_OPEN  = 2'd0,
    PH_COPY1 = 2'd1,
    PH_COPY2 = 2'd2,
    PH_CLOSE = 2'd3
  } bsf_phase_t;

  // A copy holds at most one stuffed 0: after it, at most three bits remain.
  // Find the first window of five ones in send order (MSB first).
  function automatic bsf_item_t bsf_classify(input logic [7:0] data);
    bsf_item_t item;
    logic      found;
    item.data_byte = data;
    item.has_stuff = 1'b0;
    item.stuff_pos = 3'd0;
    found          = 1'b0;
    for (int j = 8 - RUN_LIMIT; j >= 0; j--) begin
      if (!found && (&data[j +: RUN_LIMIT])) begin
        found          = 1'b1;
        item.has_stuff = 1'b1;
        item.stuff_pos = 3'(j);
      end
    end
    return item;
  endfunction

endpackage

>>> rtl/bit_stuffed_byte_framer.sv
// ----------------------------------------------------------------------------
// Bit-stuffed byte framer
// Turn each input byte into an HDLC-style serial frame, one bit per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data_byte): one beat per byte.
//   Output channel (out_valid / out_stall / out_line_bit / out_frame_end):
//   one beat per line bit, sent as flag 01111110, the byte MSB first with a
//   0 stuffed after five ones, a second stuffed copy, and the flag again.
//   out_frame_end marks the last bit of the closing flag.
//   Path: a byte passes the front register, the queue and the serializer's
//   item register before its first line bit leaves the output register.
//   The serializer sends one line bit per cycle while the output does not
//   stall, and takes the next byte as the current frame ends, so frames
//   follow each other back to back when the next byte is already queued.
//   Buffering: one byte in the front register plus two in the queue, so
//   input beats keep flowing while a frame is still being sent.
//   Reset (rst_n low, synchronous) empties the front register, queue and
//   serializer; no beat is pending after it.
//   A stall on the output holds the current bit and freezes the serializer;
//   in_stall rises once the queue is full and the front register holds a byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bit_stuffed_byte_framer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_line_bit,
  output logic       out_frame_end
);
  import bsf_pkg::*;

  logic        push, pop, q_valid;
  bsf_item_t   push_item, q_item;
  bsf_q_stat_t q_stat;

  // Accept and classify: locate the stuffed 0 once per byte.
  bsf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item)
  );

  // Decouple the front end from the serializer.
  bsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_stat    (q_stat)
  );

  // Emit the frame bit by bit through the output register.
  bsf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_line_bit  (out_line_bit),
    .out_frame_end (out_frame_end)
  );

  // The closing flag ends in 0.
  `BSF_ASSERT_IMPL(a_end_bit_zero, out_valid && out_frame_end,
                   !out_line_bit, "frame end bit not 0")
  // Queue occupancy stays within its depth.
  `BSF_ASSERT_IMPL(a_q_bound, 1'b1, q_stat.count <= 2'(QUEUE_DEPTH), "queue overflow")
  // Input backpressure only comes from a full queue.
  `BSF_ASSERT_IMPL(a_stall_full, in_stall, q_stat.full, "stall without full queue")
  // After a frame ends, the next bit sent is the opening 0 of a flag.
  `BSF_ASSERT_NEXT(a_flag_next, out_valid && out_frame_end && !out_stall,
                   !out_valid || !out_line_bit, "frame not followed by flag")

endmodule

>>> rtl/bsf_front.sv
// ----------------------------------------------------------------------------
// Framer front end
// Accept input beats, classify the byte and hand it to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  bsf_pkg::bsf_q_stat_t q_stat,
  output logic                push,
  output bsf_pkg::bsf_item_t  push_item
);
  import bsf_pkg::*;

  logic      hold_valid_r, hold_valid_nxt;
  bsf_item_t hold_item_r;
  logic      accept;

  assign in_stall  = hold_valid_r && q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign push      = hold_valid_r && !q_stat.full;
  assign push_item = hold_item_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item_r <= bsf_classify(in_data_byte);
    end
  end

endmodule

>>> rtl/bsf_queue.sv
// ----------------------------------------------------------------------------
// Framer item queue
// Two-entry FIFO between the front end and the serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bsf_pkg::bsf_item_t   push_item,
  input  logic                 pop,
  output logic                 q_valid,
  output bsf_pkg::bsf_item_t   q_item,
  output bsf_pkg::bsf_q_stat_t q_stat
);
  import bsf_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  bsf_item_t        mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_valid      = (count_r != 2'd0);
  assign q_item       = mem_r[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.full  = (count_r == 2'(QUEUE_DEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/bsf_back.sv
// ----------------------------------------------------------------------------
// Framer serializer
// Walk flag, two stuffed copies and flag, one line bit per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  bsf_pkg::bsf_item_t q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_line_bit,
  output logic               out_frame_end
);
  import bsf_pkg::*;

  bsf_phase_t phase_r, phase_nxt;
  logic       active_r, active_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_line_bit_r, out_frame_end_r;
  bsf_item_t  item_r;
  logic       ready_out, step, last, adv_copy, bit_v, end_v;

  assign out_valid     = out_valid_r;
  assign out_line_bit  = out_line_bit_r;
  assign out_frame_end = out_frame_end_r;

  assign ready_out = !out_valid_r || !out_stall;
  assign step      = active_r && ready_out;
  assign last      = (phase_r == PH_CLOSE) && (idx_r == 3'd0);
  assign pop       = q_valid && (!active_r || (step && last));

  always_comb begin
    phase_nxt     = phase_r;
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    adv_copy      = 1'b0;
    bit_v         = 1'b0;
    end_v         = 1'b0;

    if (step) begin
      out_valid_nxt = 1'b1;
      case (phase_r)
        PH_OPEN: begin
          bit_v = FLAG_PATTERN[idx_r];
          if (idx_r == 3'd0) begin
            phase_nxt = PH_COPY1;
            idx_nxt   = 3'd7;
          end else begin
            idx_nxt = idx_r - 3'd1;
          end
        end
        PH_COPY1, PH_COPY2: begin
          if (pend_r) begin
            bit_v    = 1'b0;
            pend_nxt = 1'b0;
            adv_copy = 1'b1;
          end else begin
            bit_v = item_r.data_byte[idx_r];
            if (item_r.has_stuff && (idx_r == item_r.stuff_pos)) begin
              pend_nxt = 1'b1;
            end else begin
              adv_copy = 1'b1;
            end
          end
          if (adv_copy) begin
            if (idx_r == 3'd0) begin
              phase_nxt = (phase_r == PH_COPY1) ? PH_COPY2 : PH_CLOSE;
              idx_nxt   = 3'd7;
            end else begin
              idx_nxt = idx_r - 3'd1;
            end
          end
        end
        PH_CLOSE: begin
          bit_v = FLAG_PATTERN[idx_r];
          end_v = (idx_r == 3'd0);
          if (idx_r == 3'd0) begin
            active_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r - 3'd1;
          end
        end
        default: begin
          active_nxt = 1'b0;
        end
      endcase
    end else if (ready_out) begin
      out_valid_nxt = 1'b0;
    end

    // Load the next byte; on the closing flag's last bit this chains frames.
    if (pop) begin
      active_nxt = 1'b1;
      phase_nxt  = PH_OPEN;
      idx_nxt    = 3'd7;
      pend_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPEN;
      active_r    <= 1'b0;
      idx_r       <= 3'd7;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= q_item;
    end
    if (step) begin
      out_line_bit_r  <= bit_v;
      out_frame_end_r <= end_v;
    end
  end

endmodule

>>> test/bit_stuffed_byte_framer_test.sv
// ----------------------------------------------------------------------------
// Bit-stuffed byte framer testbench
// Feeds bytes through the valid/stall input channel and checks every line
// bit of every frame, in order, against a frame builder kept in the bench.
// Both sides draw random idle cycles. The receiver holds off once for a long
// stretch so the block backs up, and the sender pauses for a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bit_stuffed_byte_framer_test;
  import bsf_pkg::*;

  localparam int CYCLE_LIMIT      = 1000000;
  localparam int RANDOM_BYTES     = 340;
  localparam int LONG_HOLD_AT     = 1500;  // line bits seen before the long hold
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES      = 40;

  typedef struct {
    logic [7:0] data;
    bit         drain_first;  // wait until every pending frame bit has left
  } byte_entry_t;

  typedef struct {
    logic line_bit;
    logic frame_end;
  } line_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b1;
  logic       out_line_bit;
  logic       out_frame_end;

  byte_entry_t byte_queue[$];     // bytes still to be offered
  line_beat_t  line_bits_due[$];  // frame bits predicted but not yet seen

  logic        in_taken = 1'b0;   // input beat accepted at the last rising edge
  logic        out_taken = 1'b0;  // output beat accepted at the last rising edge
  int unsigned failures = 0;
  int unsigned cycles = 0;
  int unsigned bytes_framed = 0;
  int unsigned stuffed_bytes = 0;
  int unsigned bits_seen = 0;
  int unsigned in_stall_run = 0;
  int unsigned in_stall_longest = 0;

  bit_stuffed_byte_framer uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_line_bit (out_line_bit),
    .out_frame_end(out_frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Frame builder: flag, two stuffed copies of the byte, closing flag.
  // --------------------------------------------------------------------------
  function automatic void push_line_bit(logic b, logic last);
    line_beat_t beat;
    beat.line_bit  = b;
    beat.frame_end = last;
    line_bits_due.push_back(beat);
  endfunction

  // Flags go out as they are; only the closing one marks frame_end.
  function automatic void push_flag(logic closing);
    for (int pos = 7; pos >= 0; pos--)
      push_line_bit(FLAG_PATTERN[pos], closing && (pos == 0));
  endfunction

  // One copy, MSB first. The run of ones restarts per copy and after each
  // stuffed 0, so ones from the flag or the other copy never carry over.
  function automatic void push_stuffed_copy(logic [7:0] b);
    int ones;
    ones = 0;
    for (int pos = 7; pos >= 0; pos--) begin
      push_line_bit(b[pos], 1'b0);
      if (b[pos]) begin
        ones++;
        if (ones >= RUN_LIMIT) begin
          push_line_bit(1'b0, 1'b0);
          ones = 0;
        end
      end else begin
        ones = 0;
      end
    end
  endfunction

  // Returns the frame length in line bits.
  function automatic int frame_byte(logic [7:0] b);
    int due_at_start;
    due_at_start = line_bits_due.size();
    push_flag(1'b0);
    push_stuffed_copy(b);
    push_stuffed_copy(b);
    push_flag(1'b1);
    return line_bits_due.size() - due_at_start;
  endfunction

  function automatic void queue_byte(logic [7:0] b, bit drain_first);
    byte_entry_t entry;
    entry.data        = b;
    entry.drain_first = drain_first;
    byte_queue.push_back(entry);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: drive at the falling edge, one nonblocking update per signal.
  // --------------------------------------------------------------------------
  int unsigned gap_left = 0;
  bit          sender_quiet = 1'b0;

  always @(negedge clk) begin
    logic        valid_nx;
    logic [7:0]  byte_nx;
    byte_entry_t entry;
    valid_nx = in_valid;
    byte_nx  = in_data_byte;
    if (rst_n) begin
      // A beat went in at the last rising edge: predict its frame, then draw a gap.
      if (in_valid && in_taken) begin
        if (frame_byte(in_data_byte) > 32)
          stuffed_bytes++;
        bytes_framed++;
        valid_nx = 1'b0;
        gap_left = sender_quiet ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 15) == 0)
          sender_quiet = !sender_quiet;
      end
      // Offer the next byte once the gap is over. A drain marker holds the
      // byte back until the frames in flight have all come out.
      if (!valid_nx) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (byte_queue.size() != 0 &&
                     !(byte_queue[0].drain_first && line_bits_due.size() != 0)) begin
          entry    = byte_queue.pop_front();
          valid_nx = 1'b1;
          byte_nx  = entry.data;
        end
      end
    end
    in_valid     <= valid_nx;
    in_data_byte <= byte_nx;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall per accepted line bit, plus one long hold-off
  // counted here so the sender keeps pushing into a full block.
  // --------------------------------------------------------------------------
  int unsigned pause_left = 0;
  int unsigned long_hold_left = 0;
  bit          long_hold_done = 1'b0;
  bit          recv_quiet = 1'b0;

  always @(negedge clk) begin
    logic stall_nx;
    stall_nx = 1'b0;
    if (rst_n) begin
      if (!long_hold_done && bits_seen >= LONG_HOLD_AT) begin
        long_hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (out_taken) begin
        pause_left = recv_quiet ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 63) == 0)
          recv_quiet = !recv_quiet;
      end
      if (long_hold_left != 0) begin
        long_hold_left--;
        stall_nx = 1'b1;
      end else if (pause_left != 0) begin
        pause_left--;
        stall_nx = 1'b1;
      end
    end
    out_stall <= stall_nx;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample at the rising edge, compare against the oldest frame bit.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    line_beat_t want;
    in_taken  <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if (in_stall) begin
        in_stall_run++;
        if (in_stall_run > in_stall_longest)
          in_stall_longest = in_stall_run;
      end else begin
        in_stall_run = 0;
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (line_bits_due.size() == 0) begin
        $error("out beat with no frame bit pending: line_bit %0b frame_end %0b",
               out_line_bit, out_frame_end);
        failures++;
      end else begin
        want = line_bits_due.pop_front();
        bits_seen++;
        if (out_line_bit !== want.line_bit) begin
          $error("line_bit: expected %0b, got %0b", want.line_bit, out_line_bit);
          failures++;
        end
        if (out_frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, out_frame_end);
          failures++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bit_stuffed_byte_framer: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] r;
    // Directed: extremes, flag look-alike, runs at both ends of the byte,
    // exactly five ones, runs broken by one zero, ones that touch across the
    // copy boundary without forming a run inside either copy.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h7E, 1'b0);
    queue_byte(8'h1F, 1'b0);  // run ends on the last data bit
    queue_byte(8'hF8, 1'b0);  // run starts on the first data bit
    queue_byte(8'h3E, 1'b0);
    queue_byte(8'h7C, 1'b0);
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'hE7, 1'b0);  // 111 at the end, 111 at the start of the next copy
    queue_byte(8'h87, 1'b0);
    queue_byte(8'hC7, 1'b0);
    queue_byte(8'h3F, 1'b0);
    queue_byte(8'hFC, 1'b0);
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'hDF, 1'b0);
    queue_byte(8'hF7, 1'b0);
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hFD, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b0);
    // Random: half plain bytes, half with a five-ones run planted somewhere.
    // Twice the sender waits for a full drain before going on.
    for (int i = 0; i < RANDOM_BYTES; i++) begin
      r = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 1)
        r = r | (8'h1F << $urandom_range(0, 3));
      queue_byte(r, (i == 0) || (i == RANDOM_BYTES * 2 / 3));
    end

    // Hold reset, then release it at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() != 0 || in_valid)
      @(posedge clk);
    while (line_bits_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("framed %0d bytes (%0d with stuffed zeros) into %0d line bits",
             bytes_framed, stuffed_bytes, bits_seen);
    $display("longest input backpressure %0d cycles, %0d cycles run",
             in_stall_longest, cycles);
    if (failures == 0) begin
      $display("bit_stuffed_byte_framer: match");
    end else begin
      $display("bit_stuffed_byte_framer: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bsf_pkg.sv
rtl/bsf_front.sv
rtl/bsf_queue.sv
rtl/bsf_back.sv
rtl/bit_stuffed_byte_framer.sv
test/bit_stuffed_byte_framer_test.sv
